### rtl/core/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, constants and address helpers of the page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int UPPER_INDEX_BITS = 10;
  localparam int LOWER_INDEX_BITS = 10;
  localparam int ADDRESS_BITS     = 32;

  localparam int WORD_BITS   = 32;
  localparam int UPPER_SHIFT = ADDRESS_BITS - UPPER_INDEX_BITS;
  localparam int OFFSET_BITS = (ADDRESS_BITS - UPPER_INDEX_BITS - LOWER_INDEX_BITS < 0) ?
                               0 : ADDRESS_BITS - UPPER_INDEX_BITS - LOWER_INDEX_BITS;

  localparam logic [WORD_BITS-1:0] ADDR_MASK   = WORD_BITS'((64'(1) << ADDRESS_BITS) - 64'(1));
  localparam logic [WORD_BITS-1:0] UPPER_MASK  = WORD_BITS'((64'(1) << UPPER_INDEX_BITS) - 64'(1));
  localparam logic [WORD_BITS-1:0] BELOW_MASK  = WORD_BITS'((64'(1) << UPPER_SHIFT) - 64'(1));
  localparam logic [WORD_BITS-1:0] OFFSET_MASK = WORD_BITS'((64'(1) << OFFSET_BITS) - 64'(1));

  // command codes
  localparam logic [1:0] CMD_TRANSLATE  = 2'd0;
  localparam logic [1:0] CMD_READ_DATA  = 2'd1;
  localparam logic [1:0] CMD_FAULT_DONE = 2'd2;

  typedef enum logic [2:0] {
    KIND_READ       = 3'd0,
    KIND_FAULT      = 3'd1,
    KIND_DONE       = 3'd2,
    KIND_UNRESOLVED = 3'd3,
    KIND_PROTOCOL   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [WORD_BITS-1:0] virtual_address;
    logic [WORD_BITS-1:0] read_data;
  } in_item_t;

  typedef struct packed {
    kind_e                kind;
    logic [WORD_BITS-1:0] address;
  } out_item_t;

  function automatic logic [WORD_BITS-1:0] upper_index(input logic [WORD_BITS-1:0] va);
    return (va >> UPPER_SHIFT) & UPPER_MASK;
  endfunction

  function automatic logic [WORD_BITS-1:0] lower_index(input logic [WORD_BITS-1:0] va);
    return (va & BELOW_MASK) >> OFFSET_BITS;
  endfunction

  function automatic logic [WORD_BITS-1:0] offset_part(input logic [WORD_BITS-1:0] va);
    return va & OFFSET_MASK;
  endfunction

endpackage

### rtl/core/ptw_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_walk
// Walk state machine: takes one item per issue, updates the walk state and
// loads the result register.
// ----------------------------------------------------------------------------
module ptw_walk
  import ptw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 issue_i,
  input  in_item_t             item_i,
  input  logic [WORD_BITS-1:0] base_i,
  output out_item_t            res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_UPPER_READ,
    PH_UPPER_FAULT,
    PH_UPPER_RETRY,
    PH_LOWER_READ,
    PH_LOWER_FAULT,
    PH_LOWER_RETRY
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [WORD_BITS-1:0] sva_q, sva_d;
  logic [WORD_BITS-1:0] entry_q, entry_d;
  out_item_t            res_q, res_d;
  logic [WORD_BITS-1:0] va;

  assign va = item_i.virtual_address & ADDR_MASK;

  always_comb begin
    phase_d       = phase_q;
    sva_d         = sva_q;
    entry_d       = entry_q;
    res_d.kind    = KIND_PROTOCOL;
    res_d.address = '0;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.cmd == CMD_TRANSLATE) begin
          sva_d         = va;
          entry_d       = base_i + (upper_index(va) << 2);
          phase_d       = PH_UPPER_READ;
          res_d.kind    = KIND_READ;
          res_d.address = entry_d;
        end
      end
      PH_UPPER_READ, PH_UPPER_RETRY: begin
        if (item_i.cmd == CMD_READ_DATA) begin
          if (item_i.read_data != '0) begin
            entry_d       = item_i.read_data + (lower_index(sva_q) << 2);
            phase_d       = PH_LOWER_READ;
            res_d.kind    = KIND_READ;
            res_d.address = entry_d;
          end else if (phase_q == PH_UPPER_READ) begin
            phase_d       = PH_UPPER_FAULT;
            res_d.kind    = KIND_FAULT;
            res_d.address = sva_q;
          end else begin
            phase_d       = PH_IDLE;
            res_d.kind    = KIND_UNRESOLVED;
            res_d.address = sva_q;
          end
        end
      end
      PH_LOWER_READ, PH_LOWER_RETRY: begin
        if (item_i.cmd == CMD_READ_DATA) begin
          if (item_i.read_data != '0) begin
            phase_d       = PH_IDLE;
            res_d.kind    = KIND_DONE;
            res_d.address = item_i.read_data + offset_part(sva_q);
          end else if (phase_q == PH_LOWER_READ) begin
            phase_d       = PH_LOWER_FAULT;
            res_d.kind    = KIND_FAULT;
            res_d.address = sva_q;
          end else begin
            phase_d       = PH_IDLE;
            res_d.kind    = KIND_UNRESOLVED;
            res_d.address = sva_q;
          end
        end
      end
      PH_UPPER_FAULT, PH_LOWER_FAULT: begin
        if (item_i.cmd == CMD_FAULT_DONE) begin
          phase_d       = (phase_q == PH_UPPER_FAULT) ? PH_UPPER_RETRY : PH_LOWER_RETRY;
          res_d.kind    = KIND_READ;
          res_d.address = entry_q;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      sva_q         <= '0;
      entry_q       <= '0;
      res_q.kind    <= KIND_READ;
      res_q.address <= '0;
    end else if (issue_i) begin
      phase_q <= phase_d;
      sva_q   <= sva_d;
      entry_q <= entry_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/core/two_level_page_table_walker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_walker_unit
// Two-level page table walker with a valid/stall item interface.
// ----------------------------------------------------------------------------
// Every accepted item (translate request, returned entry word or fault-handled
// notice) gives exactly one result item: a read request, a fault request, a
// finished translation, an unresolved fault or a protocol error. An item is
// held in the input register and is then processed by the walk stage into
// the result register, which offers it until it is taken; a stall of the
// output holds the next item in the input register. One item per cycle is
// sustained while the output does not stall; the walk state written by the
// walk stage is ready for the next item in the following cycle. The upper
// table base register is sampled when a translate request is processed.
module two_level_page_table_walker_unit
  import ptw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [WORD_BITS-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  logic [WORD_BITS-1:0] base_q;
  logic                 s1_valid_q;
  in_item_t             s1_item_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 advance;
  logic                 in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
  end

  ptw_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (advance),
    .item_i  (s1_item_q),
    .base_i  (base_q),
    .res_o   (out_item_o)
  );

  assign out_valid_o = out_valid_q;

  // a processed item always shows up as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) advance |=> out_valid_q)
    else $error("processed item did not reach the result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_item_o.kind == KIND_PROTOCOL) |-> out_item_o.address == '0)
    else $error("protocol error result with nonzero address");

  // a held result must not be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_stall_i) |-> !advance)
    else $error("result overwritten while stalled");

endmodule
